// ===== hw/rtl/ipv4fp_pkg.sv =====
// Package for the IPv4 fragment planner: item types, widths and constants.
package ipv4fp_pkg;

	localparam int unsigned MTU_W     = 14;
	localparam int unsigned HLEN_W    = 6;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned ADD_W     = 18;
	localparam int unsigned FRAG_LG2  = 6;
	localparam int unsigned CMP_W     = MTU_W + FRAG_LG2;

	localparam logic [MTU_W-1:0]  MTU_RESET      = MTU_W'(1500);
	localparam logic [WORD_W-1:0] MORE_FRAGMENTS = 16'h2000;

	typedef struct packed {
		logic [HLEN_W-1:0] header_length;
		logic [WORD_W-1:0] packet_length;
		logic [WORD_W-1:0] header_rest_sum;
		logic              wan_side;
	} in_item_t;

	typedef struct packed {
		logic              pass_through;
		logic [WORD_W-1:0] payload_offset;
		logic [WORD_W-1:0] payload_length;
		logic [WORD_W-1:0] total_length;
		logic [WORD_W-1:0] fragment_field;
		logic [WORD_W-1:0] header_checksum;
		logic              to_wan_queue;
		logic              last;
	} out_item_t;

endpackage

// ===== hw/rtl/ipv4_fragment_planner.sv =====
// IPv4 fragment planner: sequencer around one shared adder that plans fragments.
// Flow: an accepted item passes S_PAYLOAD, S_SLICE and S_CHECK; a pass-through result is then
// valid in S_OUT, a fragment after S_LEFT, S_SIZE, S_SUM1, S_SUM2, S_FOLD1 and S_FOLD2, and each
// further fragment runs S_NEXT and S_LEFT to S_FOLD2 once the previous fragment is taken. One item
// at a time: a new item is accepted only when idle, after a drop or once its last result is taken.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and mtu_q to 1500.
module ipv4_fragment_planner import ipv4fp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [MTU_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	// One-hot sequencer states. Each working state but S_CHECK and S_OUT uses the shared adder once.
	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_PAYLOAD = 12'b0000_0000_0010,
		S_SLICE   = 12'b0000_0000_0100,
		S_CHECK   = 12'b0000_0000_1000,
		S_LEFT    = 12'b0000_0001_0000,
		S_SIZE    = 12'b0000_0010_0000,
		S_SUM1    = 12'b0000_0100_0000,
		S_SUM2    = 12'b0000_1000_0000,
		S_FOLD1   = 12'b0001_0000_0000,
		S_FOLD2   = 12'b0010_0000_0000,
		S_OUT     = 12'b0100_0000_0000,
		S_NEXT    = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [MTU_W-1:0]  mtu_q;

	// Captured packet descriptor.
	logic [HLEN_W-1:0] hlen_q;
	logic [WORD_W-1:0] plen_q;
	logic [WORD_W-1:0] rest_q;
	logic              wan_q;

	// Planning state.
	logic [WORD_W-1:0] payload_q;
	logic [MTU_W-1:0]  slice_q;
	logic [WORD_W-1:0] done_q;
	logic [WORD_W-1:0] left_q;
	logic [WORD_W-1:0] size_q;
	logic              mf_q;
	logic [WORD_W-1:0] tlen_q;
	logic [WORD_W-1:0] frag_q;
	logic [ADD_W-1:0]  sum_q;
	out_item_t         out_q;

	// Shared adder. For a subtraction the top bit of the result is set when a >= b.
	logic [ADD_W-1:0] add_a;
	logic [ADD_W-1:0] add_b;
	logic             add_sub;
	logic [ADD_W:0]   add_y;

	logic              more;
	logic [WORD_W-1:0] size_next;
	logic              fits;
	logic              too_many;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = out_q;

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			S_PAYLOAD: begin
				add_a   = ADD_W'(plen_q);
				add_b   = ADD_W'(hlen_q);
				add_sub = 1'b1;
			end
			S_SLICE: begin
				add_a   = ADD_W'(mtu_q);
				add_b   = ADD_W'(hlen_q);
				add_sub = 1'b1;
			end
			S_LEFT: begin
				add_a   = ADD_W'(payload_q);
				add_b   = ADD_W'(done_q);
				add_sub = 1'b1;
			end
			S_SIZE: begin
				add_a = ADD_W'(hlen_q);
				add_b = ADD_W'(size_next);
			end
			S_SUM1: begin
				add_a = ADD_W'(rest_q);
				add_b = ADD_W'(tlen_q);
			end
			S_SUM2: begin
				add_a = sum_q;
				add_b = ADD_W'(frag_q);
			end
			S_FOLD1: begin
				add_a = ADD_W'(sum_q[WORD_W-1:0]);
				add_b = ADD_W'(sum_q[ADD_W-1:WORD_W]);
			end
			S_FOLD2: begin
				add_a = ADD_W'(sum_q[WORD_W-1:0]);
				add_b = ADD_W'(sum_q[WORD_W]);
			end
			S_NEXT: begin
				add_a = ADD_W'(done_q);
				add_b = ADD_W'(size_q);
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	assign add_y = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (ADD_W+1)'(add_sub);

	// Fragment sizing: a full slice while more than a slice is left, else the remainder.
	assign more      = (left_q > WORD_W'(slice_q));
	assign size_next = more ? WORD_W'(slice_q) : left_q;

	// A packet that fits the link passes through; one that needs more than
	// 64 slices is dropped, checked as payload > slice * 64.
	assign fits     = (plen_q <= WORD_W'(mtu_q));
	assign too_many = (CMP_W'(payload_q) > {slice_q, FRAG_LG2'(0)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mtu_q   <= MTU_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mtu_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PAYLOAD;
					end
				end
				S_PAYLOAD: state_q <= S_SLICE;
				S_SLICE:   state_q <= S_CHECK;
				S_CHECK: begin
					if (fits) begin
						state_q <= S_OUT;
					end else if (slice_q == '0 || payload_q == '0 || too_many) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LEFT;
					end
				end
				S_LEFT:  state_q <= S_SIZE;
				S_SIZE:  state_q <= S_SUM1;
				S_SUM1:  state_q <= S_SUM2;
				S_SUM2:  state_q <= S_FOLD1;
				S_FOLD1: state_q <= S_FOLD2;
				S_FOLD2: state_q <= S_OUT;
				S_OUT: begin
					if (!out_stall) begin
						state_q <= out_q.last ? S_IDLE : S_NEXT;
					end
				end
				S_NEXT:  state_q <= S_LEFT;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					hlen_q <= in_data.header_length;
					plen_q <= in_data.packet_length;
					rest_q <= in_data.header_rest_sum;
					wan_q  <= in_data.wan_side;
					done_q <= '0;
				end
			end
			S_PAYLOAD: begin
				// Payload is zero when the packet is no longer than its header.
				payload_q <= add_y[ADD_W] ? add_y[WORD_W-1:0] : '0;
			end
			S_SLICE: begin
				// Slice rounds down to a multiple of eight; zero when the MTU
				// does not exceed the header length.
				slice_q <= (add_y[ADD_W] ? add_y[MTU_W-1:0] : '0) & ~MTU_W'(7);
			end
			S_CHECK: begin
				out_q.pass_through    <= 1'b1;
				out_q.payload_offset  <= '0;
				out_q.payload_length  <= payload_q;
				out_q.total_length    <= plen_q;
				out_q.fragment_field  <= '0;
				out_q.header_checksum <= '0;
				out_q.to_wan_queue    <= wan_q;
				out_q.last            <= 1'b1;
			end
			S_LEFT: begin
				left_q <= add_y[WORD_W-1:0];
			end
			S_SIZE: begin
				size_q <= size_next;
				mf_q   <= more;
				tlen_q <= add_y[WORD_W-1:0];
				frag_q <= (more ? MORE_FRAGMENTS : '0) | WORD_W'(done_q[WORD_W-1:3]);
			end
			S_SUM1, S_SUM2, S_FOLD1: begin
				sum_q <= add_y[ADD_W-1:0];
			end
			S_FOLD2: begin
				out_q.pass_through    <= 1'b0;
				out_q.payload_offset  <= done_q;
				out_q.payload_length  <= size_q;
				out_q.total_length    <= tlen_q;
				out_q.fragment_field  <= frag_q;
				out_q.header_checksum <= ~add_y[WORD_W-1:0];
				out_q.to_wan_queue    <= wan_q;
				out_q.last            <= !mf_q;
			end
			S_NEXT: begin
				done_q <= add_y[WORD_W-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule
